[src/dqvcl_pkg.sv]
// Shared types and constants for the dq voltage circle limiter.
// Depends on nothing; every other file in src imports it.
package dqvcl_pkg;

  // 1/sqrt(3) in unsigned Q0.16.
  localparam logic [15:0] INV_SQRT3_Q16 = 16'd37837;
  // Reset value of the modulation index register, about 0.95 in Q0.16.
  localparam logic [15:0] MOD_RESET = 16'd62259;

  // Pipeline depths of the square root and divider units.
  localparam int unsigned SQRT_STEPS = 24;
  localparam int unsigned DIV_STEPS  = 16;

  typedef struct packed {
    logic signed [15:0] vd_in;
    logic signed [15:0] vq_in;
    logic        [15:0] bus_voltage;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] vd_out;
    logic signed [15:0] vq_out;
    logic               overmodulation;
  } res_t;

  // Per-item information that rides along with the divider.
  typedef struct packed {
    logic               flag;
    logic               vd_neg;
    logic               vq_neg;
    logic signed [15:0] vd;
    logic signed [15:0] vq;
  } side_t;

  // Per-item information that rides along with the square root unit.
  typedef struct packed {
    side_t       side;
    logic [31:0] prod_d;
    logic [31:0] prod_q;
  } sq_side_t;

endpackage

[src/dqvcl_sqrt_pipe.sv]
// Fully pipelined integer square root of radicand * 2^16, one result bit per stage.
// Depends on dqvcl_pkg for the sideband type and the step count.
module dqvcl_sqrt_pipe import dqvcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] radicand_i,
  input  sq_side_t    side_i,
  output logic        valid_o,
  output logic [23:0] root_o,
  output sq_side_t    side_o
);

  typedef struct packed {
    logic [26:0] rem;
    logic [23:0] root;
    logic [47:0] nbits;
    sq_side_t    side;
  } sq_stage_t;

  function automatic sq_stage_t sq_step(input sq_stage_t s);
    sq_stage_t   n;
    logic [26:0] r;
    logic [26:0] trial;
    n     = s;
    r     = {s.rem[24:0], s.nbits[47:46]};
    trial = {1'b0, s.root, 2'b01};
    if (r >= trial) begin
      n.rem  = r - trial;
      n.root = {s.root[22:0], 1'b1};
    end else begin
      n.rem  = r;
      n.root = {s.root[22:0], 1'b0};
    end
    n.nbits = {s.nbits[45:0], 2'b00};
    return n;
  endfunction

  logic      valid_q [SQRT_STEPS+1];
  sq_stage_t st_q    [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SQRT_STEPS; k++) valid_q[k] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int k = 1; k <= SQRT_STEPS; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].rem   <= '0;
    st_q[0].root  <= '0;
    st_q[0].nbits <= {radicand_i, 16'd0};
    st_q[0].side  <= side_i;
    for (int k = 1; k <= SQRT_STEPS; k++) st_q[k] <= sq_step(st_q[k-1]);
  end

  assign valid_o = valid_q[SQRT_STEPS];
  assign root_o  = st_q[SQRT_STEPS].root;
  assign side_o  = st_q[SQRT_STEPS].side;

endmodule

[src/dqvcl_div_pipe.sv]
// Fully pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on dqvcl_pkg for the sideband type and the step count.
module dqvcl_div_pipe import dqvcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [23:0] divisor_i,
  input  logic [31:0] num_d_i,
  input  logic [31:0] num_q_i,
  input  side_t       side_i,
  output logic        valid_o,
  output logic [15:0] quot_d_o,
  output logic [15:0] quot_q_o,
  output side_t       side_o
);

  typedef struct packed {
    logic [23:0] rem;
    logic [15:0] nbits;
    logic [15:0] quot;
  } lane_t;

  typedef struct packed {
    lane_t       ld;
    lane_t       lq;
    logic [23:0] divisor;
    side_t       side;
  } dv_stage_t;

  // The numerator is num * 2^8; its top 24 bits start the remainder.
  function automatic lane_t lane_init(input logic [31:0] num);
    lane_t l;
    l.rem   = num[31:8];
    l.nbits = {num[7:0], 8'd0};
    l.quot  = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [23:0] dv);
    lane_t       n;
    logic [24:0] r;
    r       = {l.rem, l.nbits[15]};
    n.nbits = {l.nbits[14:0], 1'b0};
    if (r >= {1'b0, dv}) begin
      n.rem  = 24'(r - {1'b0, dv});
      n.quot = {l.quot[14:0], 1'b1};
    end else begin
      n.rem  = r[23:0];
      n.quot = {l.quot[14:0], 1'b0};
    end
    return n;
  endfunction

  logic      valid_q [DIV_STEPS+1];
  dv_stage_t st_q    [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) valid_q[k] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int k = 1; k <= DIV_STEPS; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0].ld      <= lane_init(num_d_i);
    st_q[0].lq      <= lane_init(num_q_i);
    st_q[0].divisor <= divisor_i;
    st_q[0].side    <= side_i;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      st_q[k].ld      <= lane_step(st_q[k-1].ld, st_q[k-1].divisor);
      st_q[k].lq      <= lane_step(st_q[k-1].lq, st_q[k-1].divisor);
      st_q[k].divisor <= st_q[k-1].divisor;
      st_q[k].side    <= st_q[k-1].side;
    end
  end

  assign valid_o  = valid_q[DIV_STEPS];
  assign quot_d_o = st_q[DIV_STEPS].ld.quot;
  assign quot_q_o = st_q[DIV_STEPS].lq.quot;
  assign side_o   = st_q[DIV_STEPS].side;

endmodule

[src/dq_voltage_circle_limiter.sv]
// Top level of the dq voltage circle limiter: front multipliers, compare and output stage.
// Depends on dqvcl_pkg, dqvcl_sqrt_pipe and dqvcl_div_pipe.

// A transaction starts when start_i is high at a rising clock edge; busy_o is always low, so
// a new command may be issued in every cycle. Each command produces exactly one result
// transaction, shown on result_o for one cycle while done_o is high; the receiver must take
// it in that cycle because the block cannot hold it. On its way the command passes three
// multiplier stages in front, the entry register and the 24-stage square root pipeline, the
// entry register and the 16-stage divider pipeline, and the output register. The modulation
// index register is written through cfg_we_i and cfg_wdata_i and should only change while
// no command is in flight.
module dq_voltage_circle_limiter import dqvcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  cmd_t        cmd_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        done_o,
  output res_t        result_o
);

  // Modulation index configuration register.
  logic [15:0] mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MOD_RESET;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
    end
  end

  // The pipeline never stalls, so the command port is always open.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Stage 1: absolute values, squares and bus voltage times 1/sqrt(3).
  logic               v1_q;
  logic signed [15:0] vd1_q, vq1_q;
  logic               dneg1_q, qneg1_q;
  logic        [15:0] ad1_q, aq1_q;
  logic        [31:0] sqd1_q, sqq1_q;
  logic        [31:0] busk1_q;

  logic [15:0] abs_d, abs_q;
  assign abs_d = cmd_i.vd_in[15] ? 16'(-cmd_i.vd_in) : 16'(cmd_i.vd_in);
  assign abs_q = cmd_i.vq_in[15] ? 16'(-cmd_i.vq_in) : 16'(cmd_i.vq_in);

  // Stage 2: squared magnitude and the linear limit in Q8.8.
  logic               v2_q;
  logic signed [15:0] vd2_q, vq2_q;
  logic               dneg2_q, qneg2_q;
  logic        [15:0] ad2_q, aq2_q;
  logic        [31:0] sum2_q;
  logic        [15:0] lim2_q;

  logic [47:0] lim_full;
  assign lim_full = busk1_q * mod_q;

  // Stage 3: squared limit and the products |v| * limit for the divider.
  logic               v3_q;
  logic signed [15:0] vd3_q, vq3_q;
  logic               dneg3_q, qneg3_q;
  logic        [31:0] sum3_q;
  logic        [31:0] lim_sq3_q;
  logic        [31:0] prodd3_q, prodq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    vd1_q   <= cmd_i.vd_in;
    vq1_q   <= cmd_i.vq_in;
    dneg1_q <= cmd_i.vd_in[15];
    qneg1_q <= cmd_i.vq_in[15];
    ad1_q   <= abs_d;
    aq1_q   <= abs_q;
    sqd1_q  <= abs_d * abs_d;
    sqq1_q  <= abs_q * abs_q;
    busk1_q <= cmd_i.bus_voltage * INV_SQRT3_Q16;

    vd2_q   <= vd1_q;
    vq2_q   <= vq1_q;
    dneg2_q <= dneg1_q;
    qneg2_q <= qneg1_q;
    ad2_q   <= ad1_q;
    aq2_q   <= aq1_q;
    // Each square is at most 2^30, so the sum fits in 32 bits.
    sum2_q  <= sqd1_q + sqq1_q;
    lim2_q  <= lim_full[47:32];

    vd3_q     <= vd2_q;
    vq3_q     <= vq2_q;
    dneg3_q   <= dneg2_q;
    qneg3_q   <= qneg2_q;
    sum3_q    <= sum2_q;
    lim_sq3_q <= lim2_q * lim2_q;
    prodd3_q  <= ad2_q * lim2_q;
    prodq3_q  <= aq2_q * lim2_q;
  end

  // The vector is over the limit exactly when |v|^2 exceeds limit^2.
  sq_side_t sq_side_in;
  always_comb begin
    sq_side_in.side.flag   = sum3_q > lim_sq3_q;
    sq_side_in.side.vd_neg = dneg3_q;
    sq_side_in.side.vq_neg = qneg3_q;
    sq_side_in.side.vd     = vd3_q;
    sq_side_in.side.vq     = vq3_q;
    sq_side_in.prod_d      = prodd3_q;
    sq_side_in.prod_q      = prodq3_q;
  end

  logic        sq_valid;
  logic [23:0] mag;
  sq_side_t    sq_side_out;

  dqvcl_sqrt_pipe u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v3_q),
    .radicand_i (sum3_q),
    .side_i     (sq_side_in),
    .valid_o    (sq_valid),
    .root_o     (mag),
    .side_o     (sq_side_out)
  );

  // When the flag is clear the quotients are ignored, so a zero magnitude is harmless.
  logic        dv_valid;
  logic [15:0] quot_d, quot_q;
  side_t       dv_side;

  dqvcl_div_pipe u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sq_valid),
    .divisor_i (mag),
    .num_d_i   (sq_side_out.prod_d),
    .num_q_i   (sq_side_out.prod_q),
    .side_i    (sq_side_out.side),
    .valid_o   (dv_valid),
    .quot_d_o  (quot_d),
    .quot_q_o  (quot_q),
    .side_o    (dv_side)
  );

  // Output stage: restore signs, clamp scaled values to 16 bits, else pass the input.
  function automatic logic signed [15:0] apply_sign(input logic neg, input logic [15:0] q);
    logic signed [16:0] r;
    r = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (r > 17'sd32767) begin
      return 16'sd32767;
    end else if (r < -17'sd32768) begin
      return -16'sd32768;
    end
    return r[15:0];
  endfunction

  logic done_q;
  res_t result_q;
  res_t result_d;

  always_comb begin
    result_d.overmodulation = dv_side.flag;
    if (dv_side.flag) begin
      result_d.vd_out = apply_sign(dv_side.vd_neg, quot_d);
      result_d.vq_out = apply_sign(dv_side.vq_neg, quot_q);
    end else begin
      result_d.vd_out = dv_side.vd;
      result_d.vq_out = dv_side.vq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule
